@@ hw/rtl/dsv_pkg.sv @@
// Date string validator package: field codes, parse state type, digit accumulate
// helpers and the month length table.
// No dependencies.
package dsv_pkg;

   localparam logic [7:0] SLASH_CODE = 8'h2F;
   localparam logic [7:0] ZERO_CODE  = 8'h30;
   localparam logic [7:0] NINE_CODE  = 8'h39;

   localparam logic [1:0] PHASE_MONTH = 2'd0;
   localparam logic [1:0] PHASE_DAY   = 2'd1;
   localparam logic [1:0] PHASE_YEAR  = 2'd2;

   localparam logic [3:0] LEN_MIN   = 4'd8;
   localparam logic [3:0] LEN_MAX   = 4'd10;
   localparam logic [3:0] COUNT4_MAX = 4'd15;
   localparam logic [2:0] COUNT3_MAX = 3'd7;
   localparam logic [2:0] YEAR_DIGITS = 3'd4;
   localparam logic [6:0] MONTH_MAX = 7'd12;
   localparam logic [6:0] ACC7_MAX  = 7'd127;
   localparam logic [13:0] ACC14_MAX = 14'd16383;

   typedef struct packed {
      logic [1:0]  field_phase;
      logic [6:0]  month_accum;
      logic [6:0]  day_accum;
      logic [13:0] year_accum;
      logic [2:0]  year_digit_count;
      logic [3:0]  char_count;
      logic        error_seen;
      logic        string_ended;
      logic [3:0]  year_d3;   // oldest of the last four year digits
      logic [3:0]  year_d2;
      logic [3:0]  year_d1;
      logic [3:0]  year_d0;   // newest
   } dsv_state_type;

   typedef struct packed {
      logic        date_valid;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [13:0] year_out;
   } dsv_result_type;

   function automatic logic [6:0] acc7_step(input logic [6:0] acc, input logic [3:0] d);
      logic [10:0] v;
      v = 11'(acc) * 11'd10 + 11'(d);
      return (v > 11'(ACC7_MAX)) ? ACC7_MAX : v[6:0];
   endfunction

   function automatic logic [13:0] acc14_step(input logic [13:0] acc, input logic [3:0] d);
      logic [17:0] v;
      v = 18'(acc) * 18'd10 + 18'(d);
      return (v > 18'(ACC14_MAX)) ? ACC14_MAX : v[13:0];
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] dim;
      case (month)
         4'd2:                      dim = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   dim = 5'd30;
         default:                   dim = 5'd31;
      endcase
      return dim;
   endfunction

endpackage

@@ hw/rtl/dsv_judge.sv @@
// Date string validator final check: length, format, month range and day range
// with the Gregorian leap rule. Pure combinational; uses dsv_pkg.
module dsv_judge (
   input  dsv_pkg::dsv_state_type  st,
   output dsv_pkg::dsv_result_type result
);
   import dsv_pkg::*;

   logic       fmt_ok;
   logic       month_ok;
   logic       last_two_zero;
   logic [1:0] first_two_mod4;
   logic       leap;
   logic [4:0] dim;
   logic       day_ok;
   logic       ok;

   always_comb begin
      fmt_ok = !st.error_seen && (st.field_phase == PHASE_YEAR) &&
               (st.char_count >= LEN_MIN) && (st.char_count <= LEN_MAX) &&
               (st.year_digit_count == YEAR_DIGITS);
      month_ok = (st.month_accum >= 7'd1) && (st.month_accum <= MONTH_MAX);
      // with exactly four year digits the digit taps hold the whole year
      last_two_zero  = (st.year_d1 == 4'd0) && (st.year_d0 == 4'd0);
      first_two_mod4 = {st.year_d3[0], 1'b0} + st.year_d2[1:0];
      leap = last_two_zero ? (first_two_mod4 == 2'd0) : (st.year_accum[1:0] == 2'd0);
      dim = month_days(st.month_accum[3:0]);
      if ((st.month_accum == 7'd2) && leap) begin
         dim = 5'd29;
      end
      day_ok = (st.day_accum >= 7'd1) && (st.day_accum <= 7'(dim));
      ok = fmt_ok && month_ok && day_ok;
      result.date_valid = ok;
      result.month_out  = ok ? st.month_accum[3:0] : 4'd0;
      result.day_out    = ok ? st.day_accum[4:0] : 5'd0;
      result.year_out   = ok ? st.year_accum : 14'd0;
   end

endmodule

@@ hw/rtl/date_string_validator_core.sv @@
// Date string validator top level: request register, per-character parse update,
// result register. Uses dsv_pkg and dsv_judge.
//
// Usage:
//   Requests carry one ASCII character of an m/d/yyyy string in req_tdata; the
//   final character of each string is marked with req_tlast. A zero byte ends
//   the string early and later bytes up to the marker are ignored.
//   One response is produced per marked request: rsp_tuser is the valid flag,
//   rsp_tdata holds month, day and year (all zero when the date is invalid).
//   A marked request is held in the request register, then judged into the
//   result register, which presents its response.
//   Throughput: one request per cycle unless a marked request waits on a stalled
//   response; the parse update and the final check fit between the two registers.
//   When the receiver stalls the response holds in the result register;
//   unmarked requests keep flowing, and a marked request waits in the
//   request register until the result register frees up.
//   Reset clears the parse state and both valid flags; no clearing pass.
module date_string_validator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] month_out, [8:4] day_out, [22:9] year_out
   output logic        rsp_tuser    // date_valid
);
   import dsv_pkg::*;

   logic           in_valid_ff;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           advance;
   logic           req_accept;

   dsv_state_type  state_ff;
   dsv_state_type  state_in;
   dsv_state_type  upd;
   dsv_result_type judged;
   dsv_result_type rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   logic           is_digit;
   logic [3:0]     digit;

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      is_digit = (in_char_ff >= ZERO_CODE) && (in_char_ff <= NINE_CODE);
      digit    = in_char_ff[3:0];
      upd      = state_ff;
      if (!state_ff.string_ended) begin
         if (in_char_ff == 8'd0) begin
            upd.string_ended = 1'b1;
         end else begin
            if (state_ff.char_count < COUNT4_MAX) begin
               upd.char_count = state_ff.char_count + 4'd1;
            end
            if (state_ff.field_phase != PHASE_YEAR) begin
               if (in_char_ff == SLASH_CODE) begin
                  upd.field_phase = state_ff.field_phase + 2'd1;
               end else if (!is_digit) begin
                  upd.error_seen = 1'b1;
               end else if (state_ff.field_phase == PHASE_MONTH) begin
                  upd.month_accum = acc7_step(state_ff.month_accum, digit);
               end else begin
                  upd.day_accum = acc7_step(state_ff.day_accum, digit);
               end
            end else begin
               if (!is_digit) begin
                  upd.error_seen = 1'b1;
               end else begin
                  upd.year_accum = acc14_step(state_ff.year_accum, digit);
                  if (state_ff.year_digit_count < COUNT3_MAX) begin
                     upd.year_digit_count = state_ff.year_digit_count + 3'd1;
                  end
                  upd.year_d3 = state_ff.year_d2;
                  upd.year_d2 = state_ff.year_d1;
                  upd.year_d1 = state_ff.year_d0;
                  upd.year_d0 = digit;
               end
            end
         end
      end
      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? '0 : upd;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   dsv_judge u_judge (
      .st     (upd),
      .result (judged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_ff <= judged;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.date_valid;
   assign rsp_tdata  = {1'b0, rsp_ff.year_out, rsp_ff.day_out, rsp_ff.month_out};

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.field_phase != 2'd3)
      else $error("field phase out of range");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_valid_ff)
      else $error("marked request produced no response");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.char_count == 4'd0 && !state_ff.string_ended)
      else $error("parse state not cleared after marked request");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.date_valid |-> rsp_tdata == 24'd0)
      else $error("invalid date carries nonzero fields");

   a_valid_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.date_valid |->
         rsp_ff.month_out != 4'd0 && rsp_ff.month_out <= 4'd12 && rsp_ff.day_out != 5'd0)
      else $error("valid date with bad month or day");

endmodule

@@ tb/date_parse_checker.sv @@
`timescale 1ns / 100ps
// Date string validator checker: follows the parse of every accepted request and
// compares each response field with the predicted date. Depends on dsv_pkg.
module date_parse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [3:0] month_out, [8:4] day_out, [22:9] year_out
   input  logic        rsp_tuser,   // date_valid
   output int          fail_count,
   output int          pending_count
);
   import dsv_pkg::*;

   typedef struct {
      logic [1:0]  phase;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [13:0] year;
      logic [2:0]  year_digits;
      logic [3:0]  length;
      logic        bad;
      logic        ended;
   } parse_state_type;

   parse_state_type parse;
   dsv_result_type  expected_dates[$];

   function automatic int shift_in_digit(int acc, int digit, int cap);
      int v;
      v = acc * 10 + digit;
      return (v > cap) ? cap : v;
   endfunction

   function automatic int days_in_month(int month, int year);
      bit leap;
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      case (month)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic void fold_char(logic [7:0] c);
      logic is_digit;
      int   d;
      is_digit = (c >= ZERO_CODE) && (c <= NINE_CODE);
      d        = c - ZERO_CODE;
      if (parse.length != COUNT4_MAX) parse.length++;
      if (parse.phase != PHASE_YEAR) begin
         if (c == SLASH_CODE) parse.phase++;
         else if (!is_digit) parse.bad = 1'b1;
         else if (parse.phase == PHASE_MONTH)
            parse.month = 7'(shift_in_digit(parse.month, d, ACC7_MAX));
         else parse.day = 7'(shift_in_digit(parse.day, d, ACC7_MAX));
      end else if (!is_digit) begin
         parse.bad = 1'b1;
      end else begin
         parse.year = 14'(shift_in_digit(parse.year, d, ACC14_MAX));
         if (parse.year_digits != COUNT3_MAX) parse.year_digits++;
      end
   endfunction

   function automatic dsv_result_type date_verdict();
      dsv_result_type r;
      r = '0;
      if (!parse.bad && parse.phase == PHASE_YEAR &&
          parse.length >= LEN_MIN && parse.length <= LEN_MAX &&
          parse.year_digits == YEAR_DIGITS &&
          parse.month >= 1 && parse.month <= MONTH_MAX &&
          parse.day >= 1 && parse.day <= days_in_month(parse.month, parse.year)) begin
         r.date_valid = 1'b1;
         r.month_out  = parse.month[3:0];
         r.day_out    = parse.day[4:0];
         r.year_out   = parse.year;
      end
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      dsv_result_type want;
      if (reset) begin
         parse = '{default: '0};
         expected_dates.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $error("response with no request outstanding: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_dates.pop_front();
               compare_field("date_valid", want.date_valid, rsp_tuser);
               compare_field("month_out", want.month_out, rsp_tdata[3:0]);
               compare_field("day_out", want.day_out, rsp_tdata[8:4]);
               compare_field("year_out", want.year_out, rsp_tdata[22:9]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (!parse.ended) begin
               if (req_tdata == '0) parse.ended = 1'b1;
               else fold_char(req_tdata);
            end
            if (req_tlast) begin
               expected_dates.push_back(date_verdict());
               parse = '{default: '0};
            end
         end
      end
      pending_count = expected_dates.size();
   end

endmodule

@@ tb/date_string_validator_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the date string validator testbench: clock, reset, directed and random
// date strings, receiver backpressure and the verdict. Uses dsv_pkg and date_parse_checker.
module date_string_validator_core_tb;
   import dsv_pkg::*;

   typedef logic [7:0] char_q_type[$];

   localparam logic [7:0] END_CODE = 8'h00;
   localparam int HOLD_OFF_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          chars_sent;
   bit          hold_off_request;

   date_string_validator_core u_top (.*);
   date_parse_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic char_q_type text_chars(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic char_q_type random_date_text();
      char_q_type q;
      int      month;
      int      day;
      int      year;
      int      pos;
      string   text;
      if ($urandom_range(99) < 25) begin
         repeat ($urandom_range(14, 1)) begin
            case ($urandom_range(3))
               0:       q.push_back(SLASH_CODE);
               1:       q.push_back(8'($urandom_range(255)));
               default: q.push_back(ZERO_CODE + 8'($urandom_range(9)));
            endcase
         end
         return q;
      end
      month = $urandom_range(13);
      day   = $urandom_range(1) ? $urandom_range(32) : 28 + $urandom_range(3);
      case ($urandom_range(3))
         0:       year = $urandom_range(9999);
         1:       year = 4 * $urandom_range(2499);
         2:       year = 100 * $urandom_range(99);
         default: year = 400 * $urandom_range(24);
      endcase
      text = $urandom_range(1) ? $sformatf("%02d", month) : $sformatf("%0d", month);
      text = {text, "/", $urandom_range(1) ? $sformatf("%02d", day) : $sformatf("%0d", day)};
      text = {text, "/", $sformatf("%04d", year)};
      q    = text_chars(text);
      pos  = $urandom_range(q.size());
      case ($urandom_range(9))
         0: q[pos % q.size()] = 8'($urandom_range(255));
         1: begin
            q.insert(pos, END_CODE);
            q.push_back(8'($urandom_range(255)));
         end
         2: q.delete(pos % q.size());
         3: q.insert(pos, $urandom_range(1) ? SLASH_CODE : ZERO_CODE + 8'($urandom_range(9)));
         default: ;
      endcase
      return q;
   endfunction

   // valid is left high after acceptance; the next call or the caller changes it
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_string(input char_q_type chars);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int item_goal,
                            input bit with_hold_off);
      int goal;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (with_hold_off) hold_off_request = 1'b1;
      goal = chars_sent + item_goal;
      while (chars_sent < goal) send_string(random_date_text());
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      char_q_type chars;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tlast        = 1'b0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      chars_sent       = 0;
      hold_off_request = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_string(text_chars("12/31/9999"));
      send_string(text_chars("2/29/2000"));
      send_string(text_chars("2/29/1900"));
      send_string(text_chars("01/01/0000"));
      chars = {END_CODE};
      send_string(chars);
      chars = text_chars("9/3/2024");
      chars.push_back(END_CODE);
      chars.push_back(8'hFF);
      send_string(chars);
      send_string(text_chars("1/a/2020"));
      send_string(text_chars("//2000"));
      send_string(text_chars("1/1/2/2000"));
      send_string(text_chars("999/999/99999999"));

      run_phase(32, 57, 500, 1'b0);
      run_phase(57, 32, 500, 1'b0);
      run_phase(0, 0, 500, 1'b1);
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
